[rtl/core/dsp_pkg.sv]
package dsp_pkg;

    localparam int MAX_NODES   = 255;
    localparam int NODE_BITS   = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 24;
    localparam int NODE_LIMIT  = (MAX_NODES < 255) ? MAX_NODES : 255;
    localparam int WADDR_BITS  = 2 * NODE_BITS;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;     // clear one weight entry, advance clear address
        logic take;       // item accepted this cycle
        logic idx_rst;    // node index back to 1
        logic pick_clr;   // new scan round
        logic init_wr;    // write initial node entry
        logic scan_rd;    // read node entry for min search
        logic relax_rd;   // read node entry and weight for relaxation
        logic res_load;   // load result register
        logic res_found;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic idx_last;
        logic item_query;
        logic src_ok;
        logic pick_vld;
        logic pick_hit;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic                 visited;
        logic                 reached;
        logic [DIST_BITS-1:0] cost;
    } t_node_ent;

endpackage

[rtl/core/dsp_ctrl.sv]
module dsp_ctrl import dsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_RELAX,
        ST_RELAX_DRAIN,
        ST_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_hit, n_hit;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_hit   = r_hit;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.item_query) begin
                        if (i_stat.src_ok) begin
                            o_cmd.idx_rst = 1'b1;
                            n_state       = ST_INIT;
                        end else begin
                            n_hit   = 1'b0;
                            n_state = ST_RESULT;
                        end
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.idx_rst  = 1'b1;
                    o_cmd.pick_clr = 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!i_stat.pick_vld) begin
                    n_hit   = 1'b0;
                    n_state = ST_RESULT;
                end else if (i_stat.pick_hit) begin
                    n_hit   = 1'b1;
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.idx_rst = 1'b1;
                    n_state       = ST_RELAX;
                end
            end
            ST_RELAX: begin
                o_cmd.relax_rd = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_RELAX_DRAIN;
                end
            end
            ST_RELAX_DRAIN: begin
                // last relaxation write lands at the end of this cycle
                o_cmd.idx_rst  = 1'b1;
                o_cmd.pick_clr = 1'b1;
                n_state        = ST_SCAN;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = r_hit;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

[rtl/core/dsp_datapath.sv]
module dsp_datapath import dsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_cfg_wr_en,
    input  logic [NODE_BITS-1:0]   i_cfg_wr_data,
    input  logic                   i_command,
    input  logic [NODE_BITS-1:0]   i_source_node,
    input  logic [NODE_BITS-1:0]   i_target_node,
    input  logic [WEIGHT_BITS-1:0] i_edge_weight,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_found,
    output logic [DIST_BITS-1:0]   o_distance
);

    logic [WEIGHT_BITS-1:0] mem_weight [0:2**WADDR_BITS-1];
    t_node_ent              mem_node   [0:2**NODE_BITS-1];

    logic [NODE_BITS-1:0]   r_node_count;
    logic [WADDR_BITS-1:0]  r_clr_addr;
    logic [NODE_BITS-1:0]   r_src, r_dst;
    logic [NODE_BITS-1:0]   r_idx;
    logic                   r_rd_vld, r_rd_relax;
    logic [NODE_BITS-1:0]   r_rd_idx;
    t_node_ent              r_node_rd;
    logic [WEIGHT_BITS-1:0] r_w_rd;
    logic [DIST_BITS-1:0]   r_best;
    logic [NODE_BITS-1:0]   r_pick;
    logic                   r_pick_vld;
    logic                   r_out_valid, r_found;
    logic [DIST_BITS-1:0]   r_distance;

    logic [NODE_BITS-1:0]   nodes;
    logic                   wr_ok;
    logic [DIST_BITS-1:0]   cand;
    logic                   node_we;
    logic [NODE_BITS-1:0]   node_waddr;
    t_node_ent              node_wdata;
    logic                   scan_take;

    assign nodes = (r_node_count > NODE_BITS'(NODE_LIMIT)) ? NODE_BITS'(NODE_LIMIT)
                                                             : r_node_count;

    assign wr_ok = (i_source_node != '0) && (i_source_node <= NODE_BITS'(NODE_LIMIT)) &&
                   (i_target_node != '0) && (i_target_node <= NODE_BITS'(NODE_LIMIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_BITS'(255);
        end else if (i_cfg_wr_en) begin
            r_node_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // weight matrix: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem_weight[r_clr_addr] <= '0;
        end else if (i_cmd.take && (i_command == CMD_WRITE) && wr_ok) begin
            mem_weight[{i_source_node, i_target_node}] <= i_edge_weight;
        end
        if (i_cmd.relax_rd) begin
            r_w_rd <= mem_weight[{r_pick, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_src <= i_source_node;
            r_dst <= i_target_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_relax <= 1'b0;
        end else begin
            if (i_cmd.idx_rst) begin
                r_idx <= NODE_BITS'(1);
            end else if (i_cmd.init_wr || i_cmd.scan_rd || i_cmd.relax_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            r_rd_vld   <= i_cmd.scan_rd || i_cmd.relax_rd;
            r_rd_relax <= i_cmd.relax_rd;
        end
    end

    assign cand = r_best + DIST_BITS'(r_w_rd);

    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_rd_idx;
        node_wdata = r_node_rd;
        if (i_cmd.init_wr) begin
            node_we    = 1'b1;
            node_waddr = r_idx;
            node_wdata = '{visited: 1'b0, reached: (r_idx == r_src), cost: '0};
        end else if (r_rd_vld && r_rd_relax) begin
            if (r_rd_idx == r_pick) begin
                // the selected node leaves the frontier
                node_we            = 1'b1;
                node_wdata.visited = 1'b1;
            end else if (!r_node_rd.visited && (r_w_rd != '0) &&
                         (!r_node_rd.reached || (r_node_rd.cost > cand))) begin
                node_we    = 1'b1;
                node_wdata = '{visited: 1'b0, reached: 1'b1, cost: cand};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            mem_node[node_waddr] <= node_wdata;
        end
        if (i_cmd.scan_rd || i_cmd.relax_rd) begin
            r_node_rd <= mem_node[r_idx];
            r_rd_idx  <= r_idx;
        end
    end

    // strict compare keeps the lowest index on ties
    assign scan_take = r_rd_vld && !r_rd_relax && !r_node_rd.visited && r_node_rd.reached &&
                       (!r_pick_vld || (r_node_rd.cost < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_vld <= 1'b0;
        end else if (i_cmd.pick_clr) begin
            r_pick_vld <= 1'b0;
        end else if (scan_take) begin
            r_pick_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_take) begin
            r_best <= r_node_rd.cost;
            r_pick <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_found    <= i_cmd.res_found;
            r_distance <= i_cmd.res_found ? r_best : '0;
        end
    end

    assign o_stat.clr_last   = (r_clr_addr == '1);
    assign o_stat.idx_last   = (r_idx == nodes);
    assign o_stat.item_query = (i_command == CMD_QUERY);
    assign o_stat.src_ok     = (i_source_node != '0) && (i_source_node <= nodes);
    assign o_stat.pick_vld   = r_pick_vld;
    assign o_stat.pick_hit   = (r_pick == r_dst);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_distance  = r_distance;

endmodule

[rtl/core/dense_shortest_path_top.sv]
// Weight write: next item taken the following cycle.
// Query over n nodes: accept, init, then rounds of scan, drain, decide, relax,
//   drain, then result; scan and relax read through the one node-table read port.
// Result sits in an output register; a new item is taken while it waits.
// Reset (synchronous): a clearing pass zeroes all 65536 weight matrix entries,
//   one entry a cycle, with input stalled; configuration writes still taken.
module dense_shortest_path_top import dsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [NODE_BITS-1:0]   i_cfg_wr_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [NODE_BITS-1:0]   i_source_node,
    input  logic [NODE_BITS-1:0]   i_target_node,
    input  logic [WEIGHT_BITS-1:0] i_edge_weight,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_found,
    output logic [DIST_BITS-1:0]   o_distance
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dsp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_command     (i_command),
        .i_source_node (i_source_node),
        .i_target_node (i_target_node),
        .i_edge_weight (i_edge_weight),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_distance    (o_distance)
    );

endmodule

[rtl/core/dsp_checker.sv]
module dsp_checker import dsp_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 i_command,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_found,
    input logic [DIST_BITS-1:0] o_distance
);

    // reset starts the clearing pass with no result pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("reset did not stall input and clear output");

    // a query always keeps input stalled after it is accepted
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_QUERY) |=> o_in_stall)
        else $error("input not stalled after query item");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_distance == '0)
        else $error("unreachable result carries nonzero distance");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_found) && $stable(o_distance))
        else $error("stalled result changed");

endmodule

bind dense_shortest_path_top dsp_checker u_dsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_found     (o_found),
    .o_distance  (o_distance)
);
